### src/segh_pkg.sv
// Shared widths, types and helpers for the spring energy, gradient and Hessian pipeline.
`default_nettype none
package segh_pkg;
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int AD_W      = 32;
	localparam int SQ_W      = 2 * AD_W;
	localparam int S_W       = SQ_W + 2;
	localparam int LEN_W     = S_W / 2;
	localparam int REM_W     = LEN_W + 3;
	localparam int KL_W      = 2 * COORD_W;
	localparam int KE_W      = COORD_W + LEN_W;
	localparam int E2_W      = 2 * LEN_W;
	localparam int EK_W      = E2_W + COORD_W;
	localparam int NUM_W     = KE_W + AD_W;
	localparam int DEN_W     = LEN_W + FRAC_BITS;
	localparam int QUO_W     = KE_W;
	localparam int RQ_W      = DEN_W + QUO_W;
	localparam int MAG_W     = QUO_W + 1;
	localparam int LANES     = 7;
	localparam int NPAIR     = 6;
	localparam int ENERGY_W  = 48;
	localparam int E_SHIFT   = 2 * FRAC_BITS + 1;

	localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'h8000_0000);
	localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(64'h7FFF_FFFF);

	// row and column of each distinct Hessian entry: xx xy xz yy yz zz
	localparam int PAIR_ROW [NPAIR] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_COL [NPAIR] = '{0, 1, 2, 1, 2, 2};

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]                dneg;
		logic [2:0][AD_W-1:0]      ad;
		logic [COORD_W-1:0]        k;
		logic [COORD_W-1:0]        rl;
		logic [KL_W-1:0]           kl;
		logic [LEN_W-1:0]          len;
		logic                      eneg;
		logic                      zero;
		logic [ENERGY_W-1:0]       energy;
		logic                      esat;
		logic [2:0][COORD_W-1:0]   grad;
		logic                      gsat;
		logic [QUO_W-1:0]          amag;
	} side_t;

	typedef struct packed {
		logic [COORD_W-1:0] val;
		logic               sat;
	} sat_t;

	// clamp a sign and magnitude to a signed 32-bit field
	function automatic sat_t sat32(input logic neg, input logic [MAG_W-1:0] m);
		sat_t r;
		logic [MAG_W-1:0] mn;
		mn = ~m + MAG_W'(1);
		if (neg) begin
			if (m > NEG_LIM) begin
				r.val = 32'h8000_0000;
				r.sat = 1'b1;
			end else begin
				r.val = mn[COORD_W-1:0];
				r.sat = 1'b0;
			end
		end else begin
			if (m > POS_LIM) begin
				r.val = 32'h7FFF_FFFF;
				r.sat = 1'b1;
			end else begin
				r.val = m[COORD_W-1:0];
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### src/segh_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
`default_nettype none
module segh_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [segh_pkg::S_W-1:0]      in_s,
	input  segh_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [segh_pkg::LEN_W-1:0]    out_len,
	output segh_pkg::side_t               out_side
);
	localparam int N = segh_pkg::LEN_W;

	logic [N-1:0]                      v_s;
	logic [segh_pkg::REM_W-1:0]        rem_s   [N];
	logic [segh_pkg::LEN_W-1:0]        root_s  [N];
	logic [segh_pkg::S_W-1:0]          bits_s  [N];
	segh_pkg::side_t                   side_s  [N];

	logic [segh_pkg::REM_W-1:0]        rem_in  [N];
	logic [segh_pkg::LEN_W-1:0]        root_in [N];
	logic [segh_pkg::S_W-1:0]          bits_in [N];
	segh_pkg::side_t                   side_in [N];
	logic [segh_pkg::REM_W-1:0]        rem_sh  [N];
	logic [segh_pkg::REM_W-1:0]        trial   [N];
	logic [N-1:0]                      ge;

	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		bits_in[0] = in_s;
		side_in[0] = in_side;
		for (int i = 1; i < N; i++) begin
			rem_in[i]  = rem_s[i-1];
			root_in[i] = root_s[i-1];
			bits_in[i] = bits_s[i-1];
			side_in[i] = side_s[i-1];
		end
		for (int i = 0; i < N; i++) begin
			rem_sh[i] = {rem_in[i][segh_pkg::REM_W-3:0],
				bits_in[i][segh_pkg::S_W-1 -: 2]};
			trial[i]  = segh_pkg::REM_W'({root_in[i], 2'b01});
			ge[i]     = rem_sh[i] >= trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rem_s[i]  <= ge[i] ? rem_sh[i] - trial[i] : rem_sh[i];
				root_s[i] <= {root_in[i][segh_pkg::LEN_W-2:0], ge[i]};
				bits_s[i] <= {bits_in[i][segh_pkg::S_W-3:0], 2'b00};
				side_s[i] <= side_in[i];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_len   = root_s[N-1];
	assign out_side  = side_s[N-1];
endmodule
`default_nettype wire

### src/segh_div.sv
// Bank of pipelined restoring dividers, one quotient bit per stage, with sideband.
`default_nettype none
module segh_div (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            en,
	input  logic                                            in_valid,
	input  logic [segh_pkg::LANES-1:0][segh_pkg::NUM_W-1:0] in_num,
	input  logic [segh_pkg::LANES-1:0][segh_pkg::DEN_W-1:0] in_den,
	input  segh_pkg::side_t                                 in_side,
	output logic                                            out_valid,
	output logic [segh_pkg::LANES-1:0][segh_pkg::QUO_W-1:0] out_quo,
	output segh_pkg::side_t                                 out_side
);
	localparam int N  = segh_pkg::QUO_W;
	localparam int L  = segh_pkg::LANES;
	localparam int DW = segh_pkg::DEN_W;
	localparam int QW = segh_pkg::QUO_W;
	localparam int RW = segh_pkg::RQ_W;

	logic [N-1:0]                v_s;
	logic [L-1:0][RW-1:0]        rq_s    [N];
	logic [L-1:0][DW-1:0]        den_s   [N];
	segh_pkg::side_t             side_s  [N];

	logic [L-1:0][RW-1:0]        rq_in   [N];
	logic [L-1:0][DW-1:0]        den_in  [N];
	segh_pkg::side_t             side_in [N];
	logic [L-1:0][DW:0]          top_c   [N];
	logic [L-1:0][DW:0]          diff_c  [N];
	logic [L-1:0]                ge      [N];
	logic [L-1:0][RW-1:0]        rq_n    [N];

	always_comb begin
		for (int l = 0; l < L; l++) begin
			rq_in[0][l] = {DW'(in_num[l][segh_pkg::NUM_W-1:QW]), in_num[l][QW-1:0]};
		end
		den_in[0]  = in_den;
		side_in[0] = in_side;
		for (int i = 1; i < N; i++) begin
			rq_in[i]   = rq_s[i-1];
			den_in[i]  = den_s[i-1];
			side_in[i] = side_s[i-1];
		end
		// shift the partial remainder up one bit and subtract where it fits
		for (int i = 0; i < N; i++) begin
			for (int l = 0; l < L; l++) begin
				top_c[i][l]  = {rq_in[i][l][RW-1:QW], rq_in[i][l][QW-1]};
				diff_c[i][l] = top_c[i][l] - {1'b0, den_in[i][l]};
				ge[i][l]     = top_c[i][l] >= {1'b0, den_in[i][l]};
				rq_n[i][l]   = ge[i][l]
					? {diff_c[i][l][DW-1:0], rq_in[i][l][QW-2:0], 1'b1}
					: {top_c[i][l][DW-1:0], rq_in[i][l][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rq_s[i]   <= rq_n[i];
				den_s[i]  <= den_in[i];
				side_s[i] <= side_in[i];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < L; l++) begin
			out_quo[l] = rq_s[N-1][l][QW-1:0];
		end
	end

	assign out_valid = v_s[N-1];
	assign out_side  = side_s[N-1];
endmodule
`default_nettype wire

### src/spring_energy_gradient_hessian.sv
// Top level: spring energy, gradient and Hessian block pipeline.
// Usage:
//   One spring enters per request on the input channel (in_valid/in_ready):
//   both endpoints, stiffness and rest length, all Q16.16. One result leaves
//   per spring on the output channel (out_valid/out_ready): energy (Q32.16),
//   the gradient on the first point and the six distinct Hessian entries,
//   plus a status code (ok, zero-length spring, saturated).
//   The path from input request to result runs through the square root (33
//   stages) and three rounds of 65-stage dividers, each retiring one bit per
//   stage. One spring is taken per cycle unless the output stalls.
//   Every stage advances together; while a result waits at the output and
//   out_ready is low, the whole pipeline holds and in_ready is low, and no
//   request is lost or repeated. Empty stages carry no valid bit.
//   Reset clears every valid bit; data registers are not reset. Results are
//   in the order of the requests.
`default_nettype none
module spring_energy_gradient_hessian (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] first_x,
	input  logic [31:0] first_y,
	input  logic [31:0] first_z,
	input  logic [31:0] second_x,
	input  logic [31:0] second_y,
	input  logic [31:0] second_z,
	input  logic [31:0] stiffness,
	input  logic [31:0] rest_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] energy,
	output logic [31:0] grad_x,
	output logic [31:0] grad_y,
	output logic [31:0] grad_z,
	output logic [31:0] hess_xx,
	output logic [31:0] hess_xy,
	output logic [31:0] hess_xz,
	output logic [31:0] hess_yy,
	output logic [31:0] hess_yz,
	output logic [31:0] hess_zz,
	output logic [1:0]  status
);
	localparam int AD_W  = segh_pkg::AD_W;
	localparam int NUM_W = segh_pkg::NUM_W;
	localparam int DEN_W = segh_pkg::DEN_W;
	localparam int QUO_W = segh_pkg::QUO_W;
	localparam int MAG_W = segh_pkg::MAG_W;
	localparam int LANES = segh_pkg::LANES;
	localparam int NPAIR = segh_pkg::NPAIR;

	logic en;

	// stage 1: difference vector
	logic [2:0][31:0]     p1, p2;
	logic [2:0][32:0]     dif;
	logic [2:0][32:0]     difn;
	logic                 v_s1;
	logic [2:0]           dneg_s1;
	logic [2:0][AD_W-1:0] ad_s1;
	logic [31:0]          k_s1, rl_s1;

	// stage 2: squares and k*L
	logic                              v_s2;
	logic [2:0][segh_pkg::SQ_W-1:0]    sq_s2;
	logic [segh_pkg::KL_W-1:0]         kl_s2;
	logic [2:0]                        dneg_s2;
	logic [2:0][AD_W-1:0]              ad_s2;
	logic [31:0]                       k_s2, rl_s2;

	// stage 3: sum of squares
	logic                              v_s3;
	logic [segh_pkg::S_W-1:0]          s_s3;
	segh_pkg::side_t                   side_s3;
	segh_pkg::side_t                   side3_n;

	logic                              v_sq;
	logic [segh_pkg::LEN_W-1:0]        len_sq;
	segh_pkg::side_t                   side_sq;

	// stage 4: length error
	logic                              v_s4;
	logic [segh_pkg::LEN_W-1:0]        emag_s4;
	segh_pkg::side_t                   side_s4;
	segh_pkg::side_t                   side4_n;
	logic [segh_pkg::LEN_W-1:0]        rl_ext;

	// stages 5 to 7: wide products split into halves
	logic                              v_s5, v_s6, v_s7;
	logic [segh_pkg::KE_W-1:0]         ke_s5, ke_s6, ke_s7;
	logic [segh_pkg::E2_W-1:0]         e2_s5;
	logic [2:0][63:0]                  kllo_s5, klhi_s5;
	logic [2:0][NUM_W-1:0]             klad_s6, klad_s7;
	logic [2:0][63:0]                  kelo_s6;
	logic [2:0][64:0]                  kehi_s6;
	logic [63:0]                       eklo_s6;
	logic [65:0]                       ekhi_s6;
	logic [2:0][NUM_W-1:0]             kead_s7;
	logic [segh_pkg::EK_W-1:0]         ek_s7;
	segh_pkg::side_t                   side_s5, side_s6, side_s7;

	// divider round 1
	logic [segh_pkg::EK_W-1:0]              ek_sh;
	logic [LANES-1:0][NUM_W-1:0]            num1;
	logic [LANES-1:0][DEN_W-1:0]            den1, denl;
	segh_pkg::side_t                        side1_in;
	logic                                   v_r1;
	logic [LANES-1:0][QUO_W-1:0]            quo1;
	segh_pkg::side_t                        side_r1;

	// stages 8 and 9: gradients and second products
	logic                                   v_s8, v_s9;
	segh_pkg::side_t                        side_s8, side_s9;
	segh_pkg::side_t                        side8_n;
	segh_pkg::sat_t                         gsat_c [3];
	logic [NPAIR-1:0][63:0]                 qlo_s8;
	logic [NPAIR-1:0][64:0]                 qhi_s8;
	logic [LANES-1:0][NUM_W-1:0]            num2;

	logic                                   v_r2, v_r3;
	logic [LANES-1:0][QUO_W-1:0]            quo2, quo3;
	logic [LANES-1:0][NUM_W-1:0]            num3;
	segh_pkg::side_t                        side_r2, side_r3;

	// stage 10: Hessian combine and output register
	segh_pkg::sat_t                         hsat_c [NPAIR];
	logic [MAG_W-1:0]                       hsum   [NPAIR];
	logic [NPAIR-1:0]                       hneg;
	logic                                   any_sat;
	logic                                   v_s10;
	logic [47:0]                            energy_s10;
	logic [2:0][31:0]                       grad_s10;
	logic [NPAIR-1:0][31:0]                 hess_s10;
	segh_pkg::status_t                      status_s10;

	// advance when the output register is empty or being taken
	assign en       = !v_s10 || out_ready;
	assign in_ready = en;

	always_comb begin
		p1 = {first_z, first_y, first_x};
		p2 = {second_z, second_y, second_x};
		for (int i = 0; i < 3; i++) begin
			dif[i]  = {p1[i][31], p1[i]} - {p2[i][31], p2[i]};
			difn[i] = ~dif[i] + 33'd1;
		end
	end

	always_comb begin
		side3_n      = '0;
		side3_n.dneg = dneg_s2;
		side3_n.ad   = ad_s2;
		side3_n.k    = k_s2;
		side3_n.rl   = rl_s2;
		side3_n.kl   = kl_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_sq;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_r1;
			v_s9  <= v_s8;
			v_s10 <= v_r3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dneg_s1[i] <= dif[i][32];
				ad_s1[i]   <= dif[i][32] ? difn[i][AD_W-1:0] : dif[i][AD_W-1:0];
			end
			k_s1  <= stiffness;
			rl_s1 <= rest_length;

			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= ad_s1[i] * ad_s1[i];
			end
			kl_s2   <= k_s1 * rl_s1;
			dneg_s2 <= dneg_s1;
			ad_s2   <= ad_s1;
			k_s2    <= k_s1;
			rl_s2   <= rl_s1;

			s_s3    <= segh_pkg::S_W'(sq_s2[0]) + segh_pkg::S_W'(sq_s2[1])
				+ segh_pkg::S_W'(sq_s2[2]);
			side_s3 <= side3_n;
		end
	end

	segh_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_s      (s_s3),
		.in_side   (side_s3),
		.out_valid (v_sq),
		.out_len   (len_sq),
		.out_side  (side_sq)
	);

	assign rl_ext = segh_pkg::LEN_W'(side_sq.rl);

	always_comb begin
		side4_n      = side_sq;
		side4_n.len  = len_sq;
		side4_n.eneg = len_sq < rl_ext;
		side4_n.zero = len_sq == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side4_n;
			emag_s4 <= (len_sq < rl_ext) ? rl_ext - len_sq : len_sq - rl_ext;

			ke_s5   <= segh_pkg::KE_W'(side_s4.k) * segh_pkg::KE_W'(emag_s4);
			e2_s5   <= segh_pkg::E2_W'(emag_s4) * segh_pkg::E2_W'(emag_s4);
			for (int i = 0; i < 3; i++) begin
				kllo_s5[i] <= side_s4.kl[31:0] * side_s4.ad[i];
				klhi_s5[i] <= side_s4.kl[63:32] * side_s4.ad[i];
			end
			side_s5 <= side_s4;

			for (int i = 0; i < 3; i++) begin
				klad_s6[i] <= NUM_W'(kllo_s5[i]) + (NUM_W'(klhi_s5[i]) << 32);
				kelo_s6[i] <= ke_s5[31:0] * side_s5.ad[i];
				kehi_s6[i] <= ke_s5[64:32] * side_s5.ad[i];
			end
			eklo_s6 <= e2_s5[31:0] * side_s5.k;
			ekhi_s6 <= e2_s5[65:32] * side_s5.k;
			ke_s6   <= ke_s5;
			side_s6 <= side_s5;

			for (int i = 0; i < 3; i++) begin
				kead_s7[i] <= NUM_W'(kelo_s6[i]) + (NUM_W'(kehi_s6[i]) << 32);
			end
			ek_s7   <= segh_pkg::EK_W'(eklo_s6) + (segh_pkg::EK_W'(ekhi_s6) << 32);
			klad_s7 <= klad_s6;
			ke_s7   <= ke_s6;
			side_s7 <= side_s6;
		end
	end

	always_comb begin
		ek_sh           = ek_s7 >> segh_pkg::E_SHIFT;
		side1_in        = side_s7;
		side1_in.esat   = |ek_sh[segh_pkg::EK_W-1:segh_pkg::ENERGY_W];
		side1_in.energy = side1_in.esat ? '1 : ek_sh[segh_pkg::ENERGY_W-1:0];
		num1[0] = NUM_W'(ke_s7);
		den1[0] = DEN_W'(side_s7.len);
		for (int i = 0; i < 3; i++) begin
			num1[1+i] = klad_s7[i];
			den1[1+i] = DEN_W'(side_s7.len);
			num1[4+i] = kead_s7[i];
			den1[4+i] = {side_s7.len, {segh_pkg::FRAC_BITS{1'b0}}};
		end
	end

	segh_div u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_num    (num1),
		.in_den    (den1),
		.in_side   (side1_in),
		.out_valid (v_r1),
		.out_quo   (quo1),
		.out_side  (side_r1)
	);

	always_comb begin
		side8_n      = side_r1;
		side8_n.amag = quo1[0];
		side8_n.gsat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			gsat_c[i]       = segh_pkg::sat32(side_r1.eneg != side_r1.dneg[i],
				MAG_W'(quo1[4+i]));
			side8_n.grad[i] = gsat_c[i].val;
			side8_n.gsat    = side8_n.gsat | gsat_c[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= side8_n;
			for (int n = 0; n < NPAIR; n++) begin
				qlo_s8[n] <= quo1[1+segh_pkg::PAIR_ROW[n]][31:0]
					* side_r1.ad[segh_pkg::PAIR_COL[n]];
				qhi_s8[n] <= quo1[1+segh_pkg::PAIR_ROW[n]][64:32]
					* side_r1.ad[segh_pkg::PAIR_COL[n]];
			end
			side_s9 <= side_s8;
			for (int n = 0; n < NPAIR; n++) begin
				num2[n] <= NUM_W'(qlo_s8[n]) + (NUM_W'(qhi_s8[n]) << 32);
			end
			num2[LANES-1] <= '0;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			denl[l] = DEN_W'(side_s9.len);
		end
	end

	segh_div u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.in_num    (num2),
		.in_den    (denl),
		.in_side   (side_s9),
		.out_valid (v_r2),
		.out_quo   (quo2),
		.out_side  (side_r2)
	);

	logic [LANES-1:0][DEN_W-1:0] denl3;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num3[l]  = NUM_W'(quo2[l]);
			denl3[l] = DEN_W'(side_r2.len);
		end
	end

	segh_div u_div3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_r2),
		.in_num    (num3),
		.in_den    (denl3),
		.in_side   (side_r2),
		.out_valid (v_r3),
		.out_quo   (quo3),
		.out_side  (side_r3)
	);

	// diagonal entries add the axial term, which may cancel against it
	always_comb begin
		any_sat = side_r3.esat | side_r3.gsat;
		for (int n = 0; n < NPAIR; n++) begin
			if (segh_pkg::PAIR_ROW[n] != segh_pkg::PAIR_COL[n]) begin
				hneg[n] = side_r3.dneg[segh_pkg::PAIR_ROW[n]]
					^ side_r3.dneg[segh_pkg::PAIR_COL[n]];
				hsum[n] = MAG_W'(quo3[n]);
			end else if (!side_r3.eneg) begin
				hneg[n] = 1'b0;
				hsum[n] = MAG_W'(side_r3.amag) + MAG_W'(quo3[n]);
			end else if (quo3[n] <= side_r3.amag) begin
				hneg[n] = 1'b1;
				hsum[n] = MAG_W'(side_r3.amag) - MAG_W'(quo3[n]);
			end else begin
				hneg[n] = 1'b0;
				hsum[n] = MAG_W'(quo3[n]) - MAG_W'(side_r3.amag);
			end
			hsat_c[n] = segh_pkg::sat32(hneg[n], hsum[n]);
			any_sat   = any_sat | hsat_c[n].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			energy_s10 <= side_r3.energy;
			if (side_r3.zero) begin
				grad_s10   <= '0;
				hess_s10   <= '0;
				status_s10 <= segh_pkg::ST_ZERO;
			end else begin
				grad_s10 <= side_r3.grad;
				for (int n = 0; n < NPAIR; n++) begin
					hess_s10[n] <= hsat_c[n].val;
				end
				status_s10 <= any_sat ? segh_pkg::ST_SAT : segh_pkg::ST_OK;
			end
		end
	end

	assign out_valid = v_s10;
	assign energy    = energy_s10;
	assign grad_x    = grad_s10[0];
	assign grad_y    = grad_s10[1];
	assign grad_z    = grad_s10[2];
	assign hess_xx   = hess_s10[0];
	assign hess_xy   = hess_s10[1];
	assign hess_xz   = hess_s10[2];
	assign hess_yy   = hess_s10[3];
	assign hess_yz   = hess_s10[4];
	assign hess_zz   = hess_s10[5];
	assign status    = status_s10;

`ifndef NO_ASSERTIONS
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == segh_pkg::ST_ZERO |->
			grad_x == '0 && grad_y == '0 && grad_z == '0 && hess_xx == '0
			&& hess_xy == '0 && hess_zz == '0)
		else $error("zero-length spring with nonzero gradient or Hessian");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == segh_pkg::ST_OK || status == segh_pkg::ST_ZERO
			|| status == segh_pkg::ST_SAT)
		else $error("undefined status code");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s7 |=> v_s7 && $stable(ek_s7))
		else $error("pipeline moved during a stall");
`endif
endmodule
`default_nettype wire

### verif/testbench.sv
// Testbench for the spring energy, gradient and Hessian pipeline.
`default_nettype none
module testbench;
	typedef struct packed {
		logic [31:0] fx, fy, fz, sx, sy, sz;
		logic [31:0] k, rl;
	} spring_t;

	typedef struct packed {
		logic [47:0] energy;
		logic [2:0][31:0] grad;
		logic [5:0][31:0] hess;
		segh_pkg::status_t st;
	} force_t;

	typedef struct packed {
		spring_t sp;
		logic    typed;
		force_t  res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] first_x = '0, first_y = '0, first_z = '0;
	logic [31:0] second_x = '0, second_y = '0, second_z = '0;
	logic [31:0] stiffness = '0, rest_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [47:0] energy;
	logic [31:0] grad_x, grad_y, grad_z;
	logic [31:0] hess_xx, hess_xy, hess_xz, hess_yy, hess_yz, hess_zz;
	logic [1:0]  status;

	force_t      pending_forces[$];
	int          mismatches = 0;
	bit          quiet = 1'b0;
	bit          hold_off = 1'b0;
	bit          stimulus_done = 1'b0;

	spring_energy_gradient_hessian u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	// clamp a sign and magnitude; bit 32 marks a clamp
	function automatic logic [32:0] clamp32(input logic neg, input logic [127:0] m);
		if (neg) begin
			if (m > 128'h8000_0000) return {1'b1, 32'h8000_0000};
			return {1'b0, 32'(-m)};
		end
		if (m > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
		return {1'b0, m[31:0]};
	endfunction

	function automatic force_t spring_forces(input spring_t sp);
		force_t r;
		logic signed [32:0] d [3];
		logic [127:0] ad [3];
		logic [127:0] sq, c, len, emag, t, ke, kl, amag, g, q, bm, sum;
		logic [32:0] cl;
		logic eneg, sat, neg;
		int ri, ci;
		d[0] = $signed({sp.fx[31], sp.fx}) - $signed({sp.sx[31], sp.sx});
		d[1] = $signed({sp.fy[31], sp.fy}) - $signed({sp.sy[31], sp.sy});
		d[2] = $signed({sp.fz[31], sp.fz}) - $signed({sp.sz[31], sp.sz});
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			ad[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
			sq = sq + ad[i] * ad[i];
		end
		len = '0;
		for (int b = 34; b >= 0; b--) begin
			c = len | (128'd1 << b);
			if (c * c <= sq) len = c;
		end
		eneg = len < sp.rl;
		emag = eneg ? 128'(sp.rl) - len : len - 128'(sp.rl);
		sat = 1'b0;
		t = (emag * emag * sp.k) >> (2 * segh_pkg::FRAC_BITS + 1);
		if (t > 128'hFFFF_FFFF_FFFF) begin
			r.energy = '1;
			sat = 1'b1;
		end else begin
			r.energy = t[47:0];
		end
		r.grad = '0;
		r.hess = '0;
		if (len == 0) begin
			r.st = segh_pkg::ST_ZERO;
			return r;
		end
		ke = emag * sp.k;
		kl = 128'(sp.k) * sp.rl;
		amag = ke / len;
		for (int i = 0; i < 3; i++) begin
			g = (ke * ad[i]) / (len << segh_pkg::FRAC_BITS);
			cl = clamp32(eneg != (d[i] < 0), g);
			r.grad[i] = cl[31:0];
			sat |= cl[32];
		end
		for (int n = 0; n < 6; n++) begin
			ri = segh_pkg::PAIR_ROW[n];
			ci = segh_pkg::PAIR_COL[n];
			// intermediate quotients keep only 64 bits
			q = 128'(64'((kl * ad[ri]) / len));
			q = 128'(64'((q * ad[ci]) / len));
			bm = q / len;
			if (ri != ci) begin
				neg = (d[ri] < 0) != (d[ci] < 0);
				sum = bm;
			end else if (!eneg) begin
				neg = 1'b0;
				sum = amag + bm;
			end else if (bm <= amag) begin
				neg = 1'b1;
				sum = amag - bm;
			end else begin
				neg = 1'b0;
				sum = bm - amag;
			end
			cl = clamp32(neg, sum);
			r.hess[n] = cl[31:0];
			sat |= cl[32];
		end
		r.st = sat ? segh_pkg::ST_SAT : segh_pkg::ST_OK;
		return r;
	endfunction

	function automatic logic [31:0] near(input logic [31:0] base, input int span);
		return base + 32'($urandom_range(2 * span)) - 32'(span);
	endfunction

	function automatic spring_t random_spring();
		spring_t sp;
		int mode;
		mode = $urandom_range(9);
		sp.fx = $urandom; sp.fy = $urandom; sp.fz = $urandom;
		sp.k = $urandom;
		sp.rl = $urandom;
		if (mode == 0) begin
			sp.sx = sp.fx; sp.sy = sp.fy; sp.sz = sp.fz;
		end else if (mode <= 6) begin
			// realistic spring: endpoints close together, moderate stiffness
			sp.sx = near(sp.fx, 1 << 20);
			sp.sy = near(sp.fy, 1 << 20);
			sp.sz = near(sp.fz, 1 << 20);
			sp.k = $urandom_range(1 << 22);
			sp.rl = $urandom_range(1 << 21);
		end else if (mode == 7) begin
			sp.sx = near(sp.fx, 1 << 8);
			sp.sy = near(sp.fy, 1 << 8);
			sp.sz = near(sp.fz, 1 << 8);
			sp.rl = $urandom_range(1 << 9);
		end else begin
			sp.sx = $urandom; sp.sy = $urandom; sp.sz = $urandom;
		end
		return sp;
	endfunction

	task automatic offer(input spring_t sp);
		// drop valid for a single cycle now and then
		if (!quiet && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		first_x     <= sp.fx;
		first_y     <= sp.fy;
		first_z     <= sp.fz;
		second_x    <= sp.sx;
		second_y    <= sp.sy;
		second_z    <= sp.sz;
		stiffness   <= sp.k;
		rest_length <= sp.rl;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		row_t   rows[$];
		row_t   rw;
		force_t zero_res, sat_res;
		spring_t sp;

		zero_res = '0;
		zero_res.energy = 48'h2_0000;
		zero_res.st = segh_pkg::ST_ZERO;
		sat_res = '0;
		sat_res.energy = '1;
		sat_res.grad[0] = 32'h7FFF_FFFF;
		sat_res.hess[0] = 32'h7FFF_FFFF;
		sat_res.hess[3] = 32'h7FFF_FFFF;
		sat_res.hess[5] = 32'h7FFF_FFFF;
		sat_res.st = segh_pkg::ST_SAT;

		rows.push_back('{'{32'h10000, 32'h20000, 32'hFFFF0000, 32'h10000, 32'h20000,
			32'hFFFF0000, 32'h10000, 32'h20000}, 1'b1, zero_res});
		rows.push_back('{'{32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 32'hFFFFFFFF, 0},
			1'b1, sat_res});
		rows.push_back('{'{32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h8000}, 1'b0, '0});
		rows.push_back('{'{0, 32'h10000, 0, 0, 0, 0, 32'h10000, 32'h20000}, 1'b0, '0});
		rows.push_back('{'{0, 0, 32'hFFFF0000, 0, 0, 0, 32'h30000, 32'h8000}, 1'b0, '0});
		rows.push_back('{'{32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000},
			1'b0, '0});
		rows.push_back('{'{32'hFFFF0000, 32'h20000, 32'hFFFE0000, 0, 0, 0, 32'h50000,
			32'h30000}, 1'b0, '0});
		rows.push_back('{'{32'h1, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0});
		rows.push_back('{'{32'h1, 32'hFFFFFFFF, 32'h1, 0, 0, 0, 32'hFFFFFFFF, 0}, 1'b0, '0});
		rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 32'hFFFFFFFF}, 1'b0, '0});
		rows.push_back('{'{32'h40000, 32'h30000, 0, 0, 0, 0, 0, 32'h50000}, 1'b0, '0});
		rows.push_back('{'{32'h40000, 32'h30000, 0, 0, 0, 0, 32'h10000, 32'h50000},
			1'b0, '0});
		rows.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0});
		rows.push_back('{'{32'h100, 32'hFFFFFF00, 32'h80, 0, 0, 0, 32'hFFFFFFFF, 32'h100},
			1'b0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			rw = rows[i];
			offer(rw.sp);
			pending_forces.push_back(rw.typed ? rw.res : spring_forces(rw.sp));
		end
		for (int n = 0; n < 2000; n++) begin
			quiet = n >= 800 && n < 1100;
			hold_off = n >= 1300 && n < 1310;
			sp = random_spring();
			offer(sp);
			pending_forces.push_back(spring_forces(sp));
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
		while (pending_forces.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_forces.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// receiver: random stalls, one long hold-off so the pipeline fills and backs up
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				for (int c = 0; c < 600; c++) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= quiet || stimulus_done || $urandom_range(99) >= 24;
			end
		end
	end

	always @(posedge clk) begin
		force_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got.energy = energy;
			got.grad = {grad_z, grad_y, grad_x};
			got.hess = {hess_zz, hess_yz, hess_yy, hess_xz, hess_xy, hess_xx};
			got.st = segh_pkg::status_t'(status);
			if (pending_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_forces.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch energy exp %h got %h", want.energy, got.energy);
						$display("  grad exp %h got %h", want.grad, got.grad);
						$display("  hess exp %h got %h", want.hess, got.hess);
						$display("  status exp %0d got %0d", want.st, got.st);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire
